// ===== src/mktr_pkg.sv =====
// Shared types and constants for the multi-key top-four ranker.
`default_nettype none

package mktr_pkg;

   localparam int NAME_W      = 64;
   localparam int NAME_BYTES  = 8;
   localparam int SCORE_IN_W  = 10;
   localparam int SUBJECTS    = 4;
   localparam int SCORE_W     = 12;
   localparam int KEY_COUNT   = 5;
   localparam int TOP_COUNT   = 4;
   localparam int SHOWN_NAMES = 4;
   localparam int CNT_W       = $clog2(TOP_COUNT + 1);
   localparam int KEY_W       = 3;
   localparam int VALID_W     = 3;
   localparam int WIDE_W      = CNT_W + VALID_W;

   localparam int IN_RAW_W    = NAME_W + SUBJECTS * SCORE_IN_W;
   localparam int IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8;
   localparam int OUT_RAW_W   = SHOWN_NAMES * NAME_W + VALID_W;
   localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

   // Only the top NAME_BYTES bytes of a name are significant.
   localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} << (NAME_W - 8 * NAME_BYTES);

   localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(KEY_COUNT - 1);

   typedef logic [NAME_W-1:0]                     name_type;
   typedef logic [SCORE_W-1:0]                    score_type;
   typedef logic [CNT_W-1:0]                      cnt_type;
   typedef logic [VALID_W-1:0]                    valid_type;
   typedef logic [KEY_W-1:0]                      key_type;
   typedef logic [SHOWN_NAMES-1:0][NAME_W-1:0]    shown_type;

   typedef struct packed {
      logic load;    // rank the record held in the input register
      logic clear;   // that record closes the batch: empty the list afterwards
   } list_ctl_type;

endpackage

`default_nettype wire

// ===== src/mktr_list.sv =====
// One key's ranked list: held entries plus the single-pass insert logic.
`default_nettype none

module mktr_list
   import mktr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire list_ctl_type ctl,
   input  wire score_type    rec_score,
   input  wire name_type     rec_name,
   output shown_type         shown_name,
   output valid_type         shown_valid
);

   score_type held_score_ff [TOP_COUNT];
   name_type  held_name_ff  [TOP_COUNT];
   cnt_type   held_count_ff;

   score_type held_score_in [TOP_COUNT];
   name_type  held_name_in  [TOP_COUNT];
   cnt_type   held_count_in;
   cnt_type   count_ins;
   logic [TOP_COUNT-1:0] ahead;
   logic [WIDE_W-1:0]    count_wide;

   // An entry ranks ahead of the new record if it is occupied and has a higher
   // score, or the same score and a name that is not larger.
   always_comb begin
      for (int i = 0; i < TOP_COUNT; i++) begin
         ahead[i] = (CNT_W'(i) < held_count_ff) &&
                    ((held_score_ff[i] > rec_score) ||
                     ((held_score_ff[i] == rec_score) && (held_name_ff[i] <= rec_name)));
      end
   end

   always_comb begin
      if (ahead[0]) begin
         held_score_in[0] = held_score_ff[0];
         held_name_in[0]  = held_name_ff[0];
      end else begin
         held_score_in[0] = rec_score;
         held_name_in[0]  = rec_name;
      end
      for (int i = 1; i < TOP_COUNT; i++) begin
         if (ahead[i]) begin
            held_score_in[i] = held_score_ff[i];
            held_name_in[i]  = held_name_ff[i];
         end else if (ahead[i-1]) begin
            held_score_in[i] = rec_score;
            held_name_in[i]  = rec_name;
         end else begin
            held_score_in[i] = held_score_ff[i-1];
            held_name_in[i]  = held_name_ff[i-1];
         end
      end
   end

   always_comb begin
      if (held_count_ff < CNT_W'(TOP_COUNT)) begin
         count_ins = held_count_ff + CNT_W'(1);
      end else begin
         count_ins = held_count_ff;
      end
      held_count_in = ctl.clear ? '0 : count_ins;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
      end else if (ctl.load) begin
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < TOP_COUNT; i++) begin
            held_score_ff[i] <= held_score_in[i];
            held_name_ff[i]  <= held_name_in[i];
         end
      end
   end

   // View of the list after this record, as the batch result shows it.
   assign count_wide  = WIDE_W'(count_ins);
   assign shown_valid = (count_wide > WIDE_W'(SHOWN_NAMES)) ? VALID_W'(SHOWN_NAMES)
                                                             : VALID_W'(count_wide);

   for (genvar j = 0; j < SHOWN_NAMES; j++) begin : g_shown
      if (j < TOP_COUNT) begin : g_place
         assign shown_name[j] = (WIDE_W'(j) < count_wide) ? held_name_in[j] : '0;
      end else begin : g_none
         assign shown_name[j] = '0;
      end
   end

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= CNT_W'(TOP_COUNT))
      else $error("list holds more entries than it has places");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      (ctl.load && ctl.clear) |=> (held_count_ff == '0))
      else $error("list not emptied after the closing record");

endmodule

`default_nettype wire

// ===== src/mktr_drain.sv =====
// Batch result buffer: holds the five key results and sends them one per beat.
`default_nettype none

module mktr_drain
   import mktr_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire shown_type [KEY_COUNT-1:0]   key_names,
   input  wire valid_type [KEY_COUNT-1:0]   key_valid,
   output logic                             free,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [OUT_DATA_W-1:0]            rsp_tdata,
   output logic [KEY_W-1:0]                 rsp_tuser,
   output logic                             rsp_tlast
);

   logic      busy_ff, busy_in;
   key_type   idx_ff, idx_in;
   shown_type snap_name_ff  [KEY_COUNT];
   valid_type snap_valid_ff [KEY_COUNT];
   logic      step, finish;

   assign step   = busy_ff && rsp_tready;
   assign finish = step && (idx_ff == LAST_KEY);
   assign free   = !busy_ff || finish;

   always_comb begin
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (finish) begin
         busy_in = 1'b0;
         idx_in  = idx_ff;
      end else if (step) begin
         busy_in = busy_ff;
         idx_in  = idx_ff + KEY_W'(1);
      end else begin
         busy_in = busy_ff;
         idx_in  = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            snap_name_ff[k]  <= key_names[k];
            snap_valid_ff[k] <= key_valid[k];
         end
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == LAST_KEY);
   assign rsp_tdata  = OUT_DATA_W'({snap_valid_ff[idx_ff], snap_name_ff[idx_ff]});

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      load |-> (!busy_ff || finish))
      else $error("new batch loaded over results not yet sent");

   a_idx_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= LAST_KEY))
      else $error("result index past the last key");

   a_valid_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (snap_valid_ff[idx_ff] <= VALID_W'(SHOWN_NAMES)))
      else $error("name count above the shown places");

endmodule

`default_nettype wire

// ===== src/multi_key_top_four_ranker_top.sv =====
// Top level of the multi-key top-four ranker: input register, five lists, result buffer.
`default_nettype none

// The block ranks a batch of records under five keys: the four subject scores
// and their total. Each req beat carries one record (name and four scores);
// req_tlast marks the last record of a batch. For every key the block keeps the
// four best records, higher score first and the smaller name first on a tie.
//
// After the last record, five rsp beats follow, one per key in key order
// (rsp_tuser is the key), each with up to four names and the count of valid
// names; unused name slots are zero. rsp_tlast marks the fifth beat. The lists
// are then empty for the next batch.
//
// The result buffer holds one batch and needs five beats to empty, so a closing
// record waits in the input register until the previous batch has gone out; as
// it enters the lists, the buffer loads the batch and shows its first beat.
// Throughput: one record per cycle while no closing record waits; plain records
// keep flowing meanwhile up to that point. Each record passes from the input
// register through one compare-and-shift step into all five lists.
//
// Reset empties all lists and drops any pending results. When the receiver
// stalls, the current result beat holds and the input side stops only at the
// next closing record.

module multi_key_top_four_ranker_top
   import mktr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // name_key[63:0], score_first[73:64], score_second[83:74],
   // score_third[93:84], score_fourth[103:94]
   input  wire logic [IN_DATA_W-1:0]  req_tdata,
   input  wire logic                  req_tlast,   // last_record
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // rank_one_name[63:0], rank_two_name[127:64], rank_three_name[191:128],
   // rank_four_name[255:192], names_valid[258:256], zero fill above
   output logic [OUT_DATA_W-1:0]      rsp_tdata,
   output logic [KEY_W-1:0]           rsp_tuser,   // ranking_key[2:0]
   output logic                       rsp_tlast,   // last_result
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready
);

   logic      in_valid_ff, in_valid_in;
   logic      in_last_ff;
   name_type  in_name_ff;
   score_type in_score_ff [KEY_COUNT];

   logic         accept, consume, drain_free;
   list_ctl_type list_ctl;
   score_type    sub_score [SUBJECTS];
   score_type    total_score;

   shown_type [KEY_COUNT-1:0] key_names;
   valid_type [KEY_COUNT-1:0] key_valid;

   // A closing record may enter the lists only when the result buffer can take
   // the batch in the same cycle.
   assign consume    = in_valid_ff && (!in_last_ff || drain_free);
   assign req_tready = !in_valid_ff || consume;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      total_score = '0;
      for (int s = 0; s < SUBJECTS; s++) begin
         sub_score[s] = SCORE_W'(req_tdata[NAME_W + s*SCORE_IN_W +: SCORE_IN_W]);
         total_score  = total_score + sub_score[s];
      end
   end

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_name_ff <= req_tdata[NAME_W-1:0] & NAME_MASK;
         in_last_ff <= req_tlast;
         for (int s = 0; s < SUBJECTS; s++) begin
            in_score_ff[s] <= sub_score[s];
         end
         in_score_ff[KEY_COUNT-1] <= total_score;
      end
   end

   assign list_ctl.load  = consume;
   assign list_ctl.clear = consume && in_last_ff;

   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
      mktr_list u_list (
         .clock       (clock),
         .reset       (reset),
         .ctl         (list_ctl),
         .rec_score   (in_score_ff[k]),
         .rec_name    (in_name_ff),
         .shown_name  (key_names[k]),
         .shown_valid (key_valid[k])
      );
   end

   mktr_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (list_ctl.clear),
      .key_names  (key_names),
      .key_valid  (key_valid),
      .free       (drain_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_hold_blocked_last : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && !drain_free) |=> in_valid_ff)
      else $error("closing record dropped while results were pending");

endmodule

`default_nettype wire
